// ===== hdl/slr_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package slr_pkg;

	localparam int FRAC_BITS = 14;

	// Q30 angle and trig domain
	localparam logic [30:0] Q_ONE   = 31'h4000_0000;
	localparam logic [30:0] HALF_PI = 31'd1686629713;
	localparam logic [14:0] T_ONE   = 15'(1 << FRAC_BITS);

	// dot product to Q30 cosine
	localparam int CSH_R = (2 * FRAC_BITS >= 30) ? 2 * FRAC_BITS - 30 : 0;
	localparam int CSH_L = (2 * FRAC_BITS >= 30) ? 0 : 30 - 2 * FRAC_BITS;

	localparam int SER_STEPS = 12;
	localparam int SER_LAT   = 3;
	localparam int TRIG_LAT  = 2 + SER_STEPS * SER_LAT;
	localparam int STEP_LAT  = TRIG_LAT + 1;
	localparam int ANG_BITS  = 31;
	localparam int ACOS_LAT  = ANG_BITS * STEP_LAT;
	localparam int QUO_BITS  = 32;
	localparam int FRONT_LAT = 3;
	localparam int LAT       = FRONT_LAT + ACOS_LAT + 1 + TRIG_LAT + QUO_BITS + 2;

	// reciprocal scaling for the per-term constant divide
	localparam logic [63:0] RCP_NUM = 64'd1 << 34;

	typedef logic [9:0] div_const_t;

	localparam div_const_t COS_DIV [SER_STEPS] = '{
		10'd2, 10'd12, 10'd30, 10'd56, 10'd90, 10'd132,
		10'd182, 10'd240, 10'd306, 10'd380, 10'd462, 10'd552
	};
	localparam div_const_t SIN_DIV [SER_STEPS] = '{
		10'd6, 10'd20, 10'd42, 10'd72, 10'd110, 10'd156,
		10'd210, 10'd272, 10'd342, 10'd420, 10'd506, 10'd600
	};
	localparam logic [33:0] COS_RCP [SER_STEPS] = '{
		34'(RCP_NUM / 64'd2), 34'(RCP_NUM / 64'd12), 34'(RCP_NUM / 64'd30),
		34'(RCP_NUM / 64'd56), 34'(RCP_NUM / 64'd90), 34'(RCP_NUM / 64'd132),
		34'(RCP_NUM / 64'd182), 34'(RCP_NUM / 64'd240), 34'(RCP_NUM / 64'd306),
		34'(RCP_NUM / 64'd380), 34'(RCP_NUM / 64'd462), 34'(RCP_NUM / 64'd552)
	};
	localparam logic [33:0] SIN_RCP [SER_STEPS] = '{
		34'(RCP_NUM / 64'd6), 34'(RCP_NUM / 64'd20), 34'(RCP_NUM / 64'd42),
		34'(RCP_NUM / 64'd72), 34'(RCP_NUM / 64'd110), 34'(RCP_NUM / 64'd156),
		34'(RCP_NUM / 64'd210), 34'(RCP_NUM / 64'd272), 34'(RCP_NUM / 64'd342),
		34'(RCP_NUM / 64'd420), 34'(RCP_NUM / 64'd506), 34'(RCP_NUM / 64'd600)
	};

	typedef logic signed [15:0] comp_t;
	typedef logic signed [16:0] ncomp_t;

	typedef struct packed {
		logic [31:0]        x2;
		logic [31:0]        term;
		logic signed [34:0] sum;
	} ser_t;

	typedef struct packed {
		logic [30:0] rem;
		logic [31:0] lo;
		logic [31:0] quo;
		logic [30:0] dvs;
	} div_t;

	typedef struct packed {
		comp_t [3:0]  a;
		ncomp_t [3:0] b;
		logic [30:0]  t;
		logic         lin;
	} item_t;

endpackage
`default_nettype wire

// ===== hdl/slr_ser_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none
// One Taylor term: term = (term * x2 >> 30) / D, sum +/- term.
module slr_ser_cell import slr_pkg::*; (
	input  logic       clk,
	input  logic       en,
	input  logic       odd,
	input  logic [3:0] idx,
	input  ser_t       d,
	output ser_t       q
);

	logic [33:0]        rcp;
	logic [9:0]         dvc;
	logic [63:0]        prod;
	logic [67:0]        est;
	logic [43:0]        qd;
	logic [33:0]        rmd;
	logic [33:0]        qf;
	logic [33:0]        v_s1;
	logic [31:0]        x2_s1;
	logic signed [34:0] sum_s1;
	logic [33:0]        v_s2;
	logic [33:0]        qe_s2;
	logic [31:0]        x2_s2;
	logic signed [34:0] sum_s2;
	ser_t               out_s3;

	assign rcp  = odd ? SIN_RCP[idx] : COS_RCP[idx];
	assign dvc  = odd ? SIN_DIV[idx] : COS_DIV[idx];
	assign prod = d.term * d.x2;
	assign est  = v_s1 * rcp;
	assign qd   = qe_s2 * dvc;
	assign rmd  = v_s2 - qd[33:0];
	// estimate is at most one low
	assign qf   = (rmd >= 34'(dvc)) ? qe_s2 + 34'd1 : qe_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			v_s1   <= prod[63:30];
			x2_s1  <= d.x2;
			sum_s1 <= d.sum;
			v_s2   <= v_s1;
			qe_s2  <= est[67:34];
			x2_s2  <= x2_s1;
			sum_s2 <= sum_s1;
			out_s3.x2   <= x2_s2;
			out_s3.term <= qf[31:0];
			if (idx[0]) begin
				out_s3.sum <= sum_s2 + $signed({3'b000, qf[31:0]});
			end else begin
				out_s3.sum <= sum_s2 - $signed({3'b000, qf[31:0]});
			end
		end
	end

	assign q = out_s3;

endmodule
`default_nettype wire

// ===== hdl/slr_trig.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Q30 sine (odd) or cosine series, clamped to [0, 1.0].
module slr_trig import slr_pkg::*; (
	input  logic        clk,
	input  logic        en,
	input  logic        odd,
	input  logic [30:0] x,
	output logic [30:0] y
);

	logic [61:0] xx;
	logic [31:0] term0;
	ser_t        ch [SER_STEPS+1];
	logic [30:0] y_s2;

	assign xx    = x * x;
	assign term0 = odd ? {1'b0, x} : {1'b0, Q_ONE};

	always_ff @(posedge clk) begin
		if (en) begin
			ch[0].x2   <= xx[61:30];
			ch[0].term <= term0;
			ch[0].sum  <= $signed({3'b000, term0});
		end
	end

	for (genvar g = 0; g < SER_STEPS; g++) begin : g_cell
		slr_ser_cell u_cell (
			.clk (clk),
			.en  (en),
			.odd (odd),
			.idx (4'(g)),
			.d   (ch[g]),
			.q   (ch[g+1])
		);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (ch[SER_STEPS].sum < 0) begin
				y_s2 <= '0;
			end else if (ch[SER_STEPS].sum > $signed({4'b0000, Q_ONE})) begin
				y_s2 <= Q_ONE;
			end else begin
				y_s2 <= ch[SER_STEPS].sum[30:0];
			end
		end
	end

	assign y = y_s2;

endmodule
`default_nettype wire

// ===== hdl/slr_acos_step.sv =====
`timescale 1ns / 1ps
`default_nettype none
// One bit of the arccos search: keep the bit if cos(cand) > c and cand <= pi/2.
module slr_acos_step import slr_pkg::*; (
	input  logic        clk,
	input  logic        en,
	input  logic [4:0]  bitno,
	input  logic [30:0] theta_i,
	input  logic [30:0] c_i,
	output logic [30:0] theta_o,
	output logic [30:0] c_o
);

	logic [30:0] cand;
	logic [30:0] cosv;
	logic [30:0] cand_q [TRIG_LAT];
	logic [30:0] c_q [TRIG_LAT];
	logic [30:0] theta_s1;
	logic [30:0] c_s1;
	logic        keep;

	assign cand = theta_i | (31'd1 << bitno);

	slr_trig u_trig (
		.clk (clk),
		.en  (en),
		.odd (1'b0),
		.x   (cand),
		.y   (cosv)
	);

	always_ff @(posedge clk) begin
		if (en) begin
			cand_q[0] <= cand;
			c_q[0]    <= c_i;
			for (int i = 1; i < TRIG_LAT; i++) begin
				cand_q[i] <= cand_q[i-1];
				c_q[i]    <= c_q[i-1];
			end
		end
	end

	assign keep = (cand_q[TRIG_LAT-1] <= HALF_PI) && (cosv > c_q[TRIG_LAT-1]);

	always_ff @(posedge clk) begin
		if (en) begin
			theta_s1 <= keep ? cand_q[TRIG_LAT-1] : (cand_q[TRIG_LAT-1] & ~(31'd1 << bitno));
			c_s1     <= c_q[TRIG_LAT-1];
		end
	end

	assign theta_o = theta_s1;
	assign c_o     = c_s1;

endmodule
`default_nettype wire

// ===== hdl/slr_div_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none
// One restoring-division quotient bit.
module slr_div_cell import slr_pkg::*; (
	input  logic clk,
	input  logic en,
	input  div_t d,
	output div_t q
);

	logic [31:0] trial;
	logic [31:0] diff;
	logic        ge;
	div_t        out_s1;

	assign trial = {d.rem, d.lo[31]};
	assign diff  = trial - {1'b0, d.dvs};
	assign ge    = trial >= {1'b0, d.dvs};

	always_ff @(posedge clk) begin
		if (en) begin
			out_s1.rem <= ge ? diff[30:0] : trial[30:0];
			out_s1.lo  <= {d.lo[30:0], 1'b0};
			out_s1.quo <= {d.quo[30:0], ge};
			out_s1.dvs <= d.dvs;
		end
	end

	assign q = out_s1;

endmodule
`default_nettype wire

// ===== hdl/quaternion_slerp.sv =====
// Quaternion slerp, fully pipelined.
// Pipeline: dot-product front end, 31-bit arccos search, sub-angle stage, three sine
// series, 32-bit quotient division, blend/round.
// Throughput: one transaction per cycle; a stalled result freezes the whole pipe.
// Reset (arst_n low, asynchronous) clears only the valid pipeline; data is not reset.
`timescale 1ns / 1ps
`default_nettype none
module quaternion_slerp import slr_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_stall,
	input  logic signed [15:0] a_x,
	input  logic signed [15:0] a_y,
	input  logic signed [15:0] a_z,
	input  logic signed [15:0] a_w,
	input  logic signed [15:0] b_x,
	input  logic signed [15:0] b_y,
	input  logic signed [15:0] b_z,
	input  logic signed [15:0] b_w,
	input  logic [14:0]        blend,
	output logic               rsp_valid,
	input  logic               rsp_stall,
	output logic signed [15:0] r_x,
	output logic signed [15:0] r_y,
	output logic signed [15:0] r_z,
	output logic signed [15:0] r_w
);

	// global advance: every stage moves unless the result register is held
	logic           en;
	logic [LAT-1:0] vld_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[LAT-2:0], req_valid};
		end
	end

	assign rsp_valid = vld_q[LAT-1];
	assign en        = !(rsp_valid && rsp_stall);
	assign req_stall = !en;

	// ---- front: dot product, shorter-arc flip, cosine, blend clamp ----
	comp_t [3:0]        a_in;
	comp_t [3:0]        b_in;
	comp_t [3:0]        a_s1;
	comp_t [3:0]        b_s1;
	logic signed [31:0] p_s1 [4];
	logic [14:0]        blend_s1;
	comp_t [3:0]        a_s2;
	comp_t [3:0]        b_s2;
	logic signed [33:0] dot_s2;
	logic [14:0]        blend_s2;

	assign a_in = {a_w, a_z, a_y, a_x};
	assign b_in = {b_w, b_z, b_y, b_x};

	always_ff @(posedge clk) begin
		if (en) begin
			a_s1     <= a_in;
			b_s1     <= b_in;
			blend_s1 <= blend;
			for (int j = 0; j < 4; j++) begin
				p_s1[j] <= $signed(a_in[j]) * $signed(b_in[j]);
			end
			a_s2     <= a_s1;
			b_s2     <= b_s1;
			blend_s2 <= blend_s1;
			dot_s2   <= 34'(p_s1[0]) + 34'(p_s1[1]) + 34'(p_s1[2]) + 34'(p_s1[3]);
		end
	end

	logic [33:0] magw;
	logic [32:0] mag;
	logic [63:0] cw;
	logic [30:0] c_val;
	logic [14:0] tb;
	logic [30:0] cdiff;
	logic [40:0] cprod;
	ncomp_t      bx;
	item_t       it_f;
	item_t       item_s3;
	logic [30:0] c_s3;

	always_comb begin
		magw  = dot_s2[33] ? 34'(-dot_s2) : 34'(dot_s2);
		mag   = magw[32:0];
		cw    = (64'(mag) >> CSH_R) << CSH_L;
		// unnormalized inputs: cosine clamps to one and goes linear
		c_val = (cw > 64'(Q_ONE)) ? Q_ONE : cw[30:0];
		tb    = (blend_s2 > T_ONE) ? T_ONE : blend_s2;
		cdiff = Q_ONE - c_val;
		cprod = 41'(cdiff) * 41'd1000;
		it_f.a = a_s2;
		for (int j = 0; j < 4; j++) begin
			bx = ncomp_t'($signed(b_s2[j]));
			it_f.b[j] = dot_s2[33] ? -bx : bx;
		end
		it_f.t   = 31'(tb) << (30 - FRAC_BITS);
		it_f.lin = !(cprod > 41'(Q_ONE));
	end

	always_ff @(posedge clk) begin
		if (en) begin
			item_s3 <= it_f;
			c_s3    <= c_val;
		end
	end

	// ---- arccos: one search bit per step, MSB first ----
	logic [30:0] th_ch [ANG_BITS+1];
	logic [30:0] c_ch [ANG_BITS];

	assign th_ch[0] = '0;
	assign c_ch[0]  = c_s3;

	for (genvar g = 0; g < ANG_BITS; g++) begin : g_acos
		if (g == ANG_BITS - 1) begin : g_last
			slr_acos_step u_step (
				.clk     (clk),
				.en      (en),
				.bitno   (5'(ANG_BITS - 1 - g)),
				.theta_i (th_ch[g]),
				.c_i     (c_ch[g]),
				.theta_o (th_ch[g+1]),
				.c_o     ()
			);
		end else begin : g_mid
			slr_acos_step u_step (
				.clk     (clk),
				.en      (en),
				.bitno   (5'(ANG_BITS - 1 - g)),
				.theta_i (th_ch[g]),
				.c_i     (c_ch[g]),
				.theta_o (th_ch[g+1]),
				.c_o     (c_ch[g+1])
			);
		end
	end

	// operands wait alongside the search
	item_t dla_q [ACOS_LAT];

	always_ff @(posedge clk) begin
		if (en) begin
			dla_q[0] <= item_s3;
			for (int i = 1; i < ACOS_LAT; i++) begin
				dla_q[i] <= dla_q[i-1];
			end
		end
	end

	// ---- sub-angles theta*(1-t) and theta*t ----
	item_t       it_a;
	logic [61:0] m0;
	logic [61:0] m1;
	logic [30:0] ang0_s4;
	logic [30:0] ang1_s4;
	logic [30:0] theta_s4;
	item_t       item_s4;

	assign it_a = dla_q[ACOS_LAT-1];
	assign m0   = th_ch[ANG_BITS] * (Q_ONE - it_a.t);
	assign m1   = th_ch[ANG_BITS] * it_a.t;

	always_ff @(posedge clk) begin
		if (en) begin
			ang0_s4  <= m0[60:30];
			ang1_s4  <= m1[60:30];
			theta_s4 <= th_ch[ANG_BITS];
			item_s4  <= it_a;
		end
	end

	// ---- three sine series side by side ----
	logic [30:0] sth;
	logic [30:0] sa0;
	logic [30:0] sa1;

	slr_trig u_sin_th (.clk(clk), .en(en), .odd(1'b1), .x(theta_s4), .y(sth));
	slr_trig u_sin_a0 (.clk(clk), .en(en), .odd(1'b1), .x(ang0_s4), .y(sa0));
	slr_trig u_sin_a1 (.clk(clk), .en(en), .odd(1'b1), .x(ang1_s4), .y(sa1));

	item_t dlb_q [TRIG_LAT];

	always_ff @(posedge clk) begin
		if (en) begin
			dlb_q[0] <= item_s4;
			for (int i = 1; i < TRIG_LAT; i++) begin
				dlb_q[i] <= dlb_q[i-1];
			end
		end
	end

	// ---- weights: (sin(ang) << 30) / sin(theta), one bit per cell ----
	item_t it_b;
	item_t it_bz;
	div_t  dv0 [QUO_BITS+1];
	div_t  dv1 [QUO_BITS+1];

	always_comb begin
		it_b  = dlb_q[TRIG_LAT-1];
		it_bz = it_b;
		// zero sine falls back to the linear weights
		it_bz.lin = it_b.lin || (sth == '0);
		dv0[0].rem = {2'b00, sa0[30:2]};
		dv0[0].lo  = {sa0[1:0], 30'b0};
		dv0[0].quo = '0;
		dv0[0].dvs = sth;
		dv1[0].rem = {2'b00, sa1[30:2]};
		dv1[0].lo  = {sa1[1:0], 30'b0};
		dv1[0].quo = '0;
		dv1[0].dvs = sth;
	end

	for (genvar g = 0; g < QUO_BITS; g++) begin : g_div
		slr_div_cell u_dv0 (.clk(clk), .en(en), .d(dv0[g]), .q(dv0[g+1]));
		slr_div_cell u_dv1 (.clk(clk), .en(en), .d(dv1[g]), .q(dv1[g+1]));
	end

	item_t dlc_q [QUO_BITS];

	always_ff @(posedge clk) begin
		if (en) begin
			dlc_q[0] <= it_bz;
			for (int i = 1; i < QUO_BITS; i++) begin
				dlc_q[i] <= dlc_q[i-1];
			end
		end
	end

	// ---- blend: a*k0 + b*k1, round half up, saturate ----
	item_t              it_c;
	logic [32:0]        w0;
	logic [32:0]        w1;
	logic signed [50:0] pa_s5 [4];
	logic signed [50:0] pb_s5 [4];

	assign it_c = dlc_q[QUO_BITS-1];
	assign w0   = it_c.lin ? 33'(Q_ONE - it_c.t) : {1'b0, dv0[QUO_BITS].quo};
	assign w1   = it_c.lin ? 33'(it_c.t) : {1'b0, dv1[QUO_BITS].quo};

	always_ff @(posedge clk) begin
		if (en) begin
			for (int j = 0; j < 4; j++) begin
				pa_s5[j] <= $signed(it_c.a[j]) * $signed({1'b0, w0});
				pb_s5[j] <= $signed(it_c.b[j]) * $signed({1'b0, w1});
			end
		end
	end

	logic signed [50:0] acc [4];
	logic signed [20:0] shv [4];
	comp_t [3:0]        rsat;
	comp_t [3:0]        r_s6;

	always_comb begin
		for (int j = 0; j < 4; j++) begin
			acc[j] = pa_s5[j] + pb_s5[j] + 51'sd536870912;
			shv[j] = 21'(acc[j] >>> 30);
			if (shv[j] > 21'sd32767) begin
				rsat[j] = 16'sh7fff;
			end else if (shv[j] < -21'sd32768) begin
				rsat[j] = 16'sh8000;
			end else begin
				rsat[j] = shv[j][15:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			r_s6 <= rsat;
		end
	end

	assign r_x = r_s6[0];
	assign r_y = r_s6[1];
	assign r_z = r_s6[2];
	assign r_w = r_s6[3];

endmodule
`default_nettype wire

// ===== hdl/slr_check.sv =====
`timescale 1ns / 1ps
`default_nettype none
module slr_check (
	input logic               clk,
	input logic               arst_n,
	input logic               req_valid,
	input logic               req_stall,
	input logic               rsp_valid,
	input logic               rsp_stall,
	input logic signed [15:0] r_x,
	input logic signed [15:0] r_y,
	input logic signed [15:0] r_z,
	input logic signed [15:0] r_w
);

	// held result keeps its transaction
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(r_x) && $stable(r_y)
			&& $stable(r_z) && $stable(r_w))
		else $error("result changed while stalled");

	// input only stalls behind a held result
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		req_stall |-> rsp_valid && rsp_stall)
		else $error("request stalled without a held result");

	// a held result must stop new requests
	a_stall_prop: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |-> req_stall)
		else $error("request accepted while result held");

	// a freed output lets the request side through
	a_free: assert property (@(posedge clk) disable iff (!arst_n)
		!rsp_valid |-> !req_stall)
		else $error("request stalled with empty output");

endmodule

bind quaternion_slerp slr_check u_slr_check (.*);
`default_nettype wire
